>>> sv/bmqm_pkg.sv
// ----------------------------------------------------------------------------
// bmqm_pkg
// shared widths, payload structs and codes for the mask quality metrics core
// ----------------------------------------------------------------------------
package bmqm_pkg;

   localparam int CNT_W      = 24;
   localparam int FRAC_W     = 16;
   localparam int Q_W        = FRAC_W + 1;
   localparam int PIX_W      = 8;
   localparam int BETA_W     = 4;
   localparam int B2_W       = 2 * BETA_W;
   localparam int WT_W       = B2_W;
   localparam int PROD_W     = WT_W + CNT_W;
   localparam int DEN_W      = PROD_W + 1;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(2);

   typedef enum logic [2:0] {
      M_PREC  = 3'd0,
      M_REC   = 3'd1,
      M_SPEC  = 3'd2,
      M_F1    = 3'd3,
      M_FBETA = 3'd4
   } metric_type;

   typedef struct packed {
      logic [PIX_W-1:0] truth_pixel;
      logic [PIX_W-1:0] pred_pixel;
      logic             frame_end;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] true_pos;
      logic [CNT_W-1:0] false_neg;
      logic [CNT_W-1:0] false_pos;
      logic [CNT_W-1:0] true_neg;
      logic [Q_W-1:0]   precision_q;
      logic [Q_W-1:0]   recall_q;
      logic [Q_W-1:0]   specificity_q;
      logic [Q_W-1:0]   f_one_q;
      logic [Q_W-1:0]   f_beta_q;
      logic             count_overflow;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] tp;
      logic [CNT_W-1:0] fn;
      logic [CNT_W-1:0] fp;
      logic [CNT_W-1:0] tn;
      logic             sat;
   } snap_type;

   typedef struct packed {
      logic             start;
      logic [DEN_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] quo;
   } div_rsp_type;

endpackage

>>> sv/bmqm_front.sv
// ----------------------------------------------------------------------------
// bmqm_front
// classifies pixel pairs and keeps the four saturating confusion counters
// ----------------------------------------------------------------------------
module bmqm_front
   import bmqm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  pix,
   output logic     snap_push,
   output snap_type snap
);

   logic [CNT_W-1:0] tp_ff, fn_ff, fp_ff, tn_ff;
   logic [CNT_W-1:0] tp_in, fn_in, fp_in, tn_in;
   logic             sat_ff, sat_in;
   logic             truth_fg, pred_fg;

   assign truth_fg = |pix.truth_pixel;
   assign pred_fg  = |pix.pred_pixel;

   always_comb begin
      tp_in  = tp_ff;
      fn_in  = fn_ff;
      fp_in  = fp_ff;
      tn_in  = tn_ff;
      sat_in = sat_ff;
      if (accept) begin
         case ({truth_fg, pred_fg})
            2'b11: begin
               if (&tp_ff) sat_in = 1'b1;
               else tp_in = tp_ff + 1'b1;
            end
            2'b10: begin
               if (&fn_ff) sat_in = 1'b1;
               else fn_in = fn_ff + 1'b1;
            end
            2'b01: begin
               if (&fp_ff) sat_in = 1'b1;
               else fp_in = fp_ff + 1'b1;
            end
            default: begin
               if (&tn_ff) sat_in = 1'b1;
               else tn_in = tn_ff + 1'b1;
            end
         endcase
      end
   end

   assign snap_push = accept & pix.frame_end;
   assign snap      = '{tp: tp_in, fn: fn_in, fp: fp_in, tn: tn_in, sat: sat_in};

   always_ff @(posedge clock) begin
      if (reset || snap_push) begin
         tp_ff  <= '0;
         fn_ff  <= '0;
         fp_ff  <= '0;
         tn_ff  <= '0;
         sat_ff <= 1'b0;
      end else begin
         tp_ff  <= tp_in;
         fn_ff  <= fn_in;
         fp_ff  <= fp_in;
         tn_ff  <= tn_in;
         sat_ff <= sat_in;
      end
   end

endmodule

>>> sv/bmqm_fifo.sv
// ----------------------------------------------------------------------------
// bmqm_fifo
// short register queue holding frame snapshots between front and back
// ----------------------------------------------------------------------------
module bmqm_fifo
   import bmqm_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int W     = $bits(snap_type)
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wr_data,
   input  logic         pop,
   output logic [W-1:0] rd_data,
   output logic         full,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [W-1:0]        mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

>>> sv/bmqm_div.sv
// ----------------------------------------------------------------------------
// bmqm_div
// restoring fraction divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bmqm_div
   import bmqm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int ITER_W = $clog2(FRAC_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [ITER_W-1:0]   cnt_ff, cnt_in;
   logic [DEN_W-1:0]    r_ff, r_in, den_ff, den_in;
   logic [FRAC_W-1:0]   q_ff, q_in;
   logic [Q_W-1:0]      quo_ff, quo_in;
   logic [DEN_W:0]      shifted;
   logic                ge;

   assign shifted = {r_ff, 1'b0};
   assign ge      = (shifted >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      quo_in  = quo_ff;
      if (busy_ff) begin
         r_in   = ge ? DEN_W'(shifted - {1'b0, den_ff}) : DEN_W'(shifted);
         q_in   = {q_ff[FRAC_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = {1'b0, q_in};
         end
      end else if (req.start) begin
         if (req.den == '0) begin
            done_in = 1'b1;
            quo_in  = '0;
         end else if (req.num >= req.den) begin
            done_in = 1'b1;
            quo_in  = Q_W'(1) << FRAC_W;
         end else begin
            busy_in = 1'b1;
            r_in    = req.num;
            den_in  = req.den;
            q_in    = '0;
            cnt_in  = ITER_W'(FRAC_W);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      quo_ff <= quo_in;
   end

   assign rsp = '{done: done_ff, quo: quo_ff};

endmodule

>>> sv/bmqm_back.sv
// ----------------------------------------------------------------------------
// bmqm_back
// per-frame sequencer: beta weights, five fractions, result register
// ----------------------------------------------------------------------------
module bmqm_back
   import bmqm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              snap_empty,
   input  snap_type          snap,
   output logic              snap_pop,
   input  logic [BETA_W-1:0] beta,
   input  logic              pop,
   output logic              empty,
   output rsp_type           rsp_data
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_PREP = 6'b000010,
      S_MULT = 6'b000100,
      S_LOAD = 6'b001000,
      S_WAIT = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   metric_type        sel_ff, sel_in;
   snap_type          snap_ff, snap_in;
   logic [B2_W-1:0]   b2_ff, b2_in;
   logic [PROD_W-1:0] fbn_ff, fbn_in, b2fn_ff, b2fn_in;
   logic [WT_W-1:0]   wt;
   logic [Q_W-1:0]    prec_ff, rec_ff, spec_ff, f1_ff, fb_ff;
   logic [Q_W-1:0]    prec_in, rec_in, spec_in, f1_in, fb_in;
   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   logic [DEN_W-1:0]  tp_d, fn_d, fp_d, tn_d;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   assign tp_d = DEN_W'(snap_ff.tp);
   assign fn_d = DEN_W'(snap_ff.fn);
   assign fp_d = DEN_W'(snap_ff.fp);
   assign tn_d = DEN_W'(snap_ff.tn);
   assign wt   = b2_ff + 1'b1;

   // operand select for the shared divider
   always_comb begin
      div_req.start = (state_ff == S_LOAD);
      unique case (sel_ff)
         M_PREC: begin
            div_req.num = tp_d;
            div_req.den = tp_d + fp_d;
         end
         M_REC: begin
            div_req.num = tp_d;
            div_req.den = tp_d + fn_d;
         end
         M_SPEC: begin
            div_req.num = tn_d;
            div_req.den = tn_d + fp_d;
         end
         M_F1: begin
            div_req.num = tp_d << 1;
            div_req.den = (tp_d << 1) + fn_d + fp_d;
         end
         M_FBETA: begin
            div_req.num = DEN_W'(fbn_ff);
            div_req.den = DEN_W'(fbn_ff) + DEN_W'(b2fn_ff) + fp_d;
         end
         default: begin
            div_req.num = '0;
            div_req.den = '0;
         end
      endcase
   end

   bmqm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      snap_in      = snap_ff;
      b2_in        = b2_ff;
      fbn_in       = fbn_ff;
      b2fn_in      = b2fn_ff;
      prec_in      = prec_ff;
      rec_in       = rec_ff;
      spec_in      = spec_ff;
      f1_in        = f1_ff;
      fb_in        = fb_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~pop;
      snap_pop     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!snap_empty) begin
               snap_pop = 1'b1;
               snap_in  = snap;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            b2_in    = B2_W'(beta) * B2_W'(beta);
            state_in = S_MULT;
         end
         S_MULT: begin
            fbn_in   = PROD_W'(wt) * PROD_W'(snap_ff.tp);
            b2fn_in  = PROD_W'(b2_ff) * PROD_W'(snap_ff.fn);
            sel_in   = M_PREC;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_rsp.done) begin
               state_in = S_LOAD;
               case (sel_ff)
                  M_PREC: begin
                     prec_in = div_rsp.quo;
                     sel_in  = M_REC;
                  end
                  M_REC: begin
                     rec_in = div_rsp.quo;
                     sel_in = M_SPEC;
                  end
                  M_SPEC: begin
                     spec_in = div_rsp.quo;
                     sel_in  = M_F1;
                  end
                  M_F1: begin
                     f1_in  = div_rsp.quo;
                     sel_in = M_FBETA;
                  end
                  default: begin
                     fb_in    = div_rsp.quo;
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (!out_valid_ff || pop) begin
               out_in = '{true_pos:       snap_ff.tp,
                          false_neg:      snap_ff.fn,
                          false_pos:      snap_ff.fp,
                          true_neg:       snap_ff.tn,
                          precision_q:    prec_ff,
                          recall_q:       rec_ff,
                          specificity_q:  spec_ff,
                          f_one_q:        f1_ff,
                          f_beta_q:       fb_ff,
                          count_overflow: snap_ff.sat};
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= M_PREC;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      b2_ff   <= b2_in;
      fbn_ff  <= fbn_in;
      b2fn_ff <= b2fn_in;
      prec_ff <= prec_in;
      rec_ff  <= rec_in;
      spec_ff <= spec_in;
      f1_ff   <= f1_in;
      fb_ff   <= fb_in;
      out_ff  <= out_in;
   end

   assign empty    = ~out_valid_ff;
   assign rsp_data = out_ff;

endmodule

>>> sv/binary_mask_quality_metrics_core.sv
// ----------------------------------------------------------------------------
// binary_mask_quality_metrics_core
// confusion counts, precision, recall, specificity, F1 and F-beta per frame
// ----------------------------------------------------------------------------
// Pixel beats enter through a queue-style port: push with req_data while full
// is low. Any nonzero pixel is foreground. Pixels are taken every cycle; full
// rises only when QUEUE_DEPTH finished frames are still waiting for the back
// end. A beat with frame_end closes the frame: its counts are snapshotted,
// the counters clear, and the next frame starts on the following beat.
// Each frame gives one result beat on rsp_data, shown while empty is low and
// taken with pop. The back end works one frame at a time: it forms the
// beta weights in S_PREP and S_MULT, then computes five fractions in turn
// on one shared divider at one quotient bit a cycle.
// If pop is held low, the finished result waits in the output register, the
// next frame is computed and held in the back end, and later frames wait in
// the snapshot queue; the front keeps counting until that queue is full.
// The beta register is written with valid and csr_beta (ready is always
// high); the user must write it only while the block is idle, which the
// block itself does not enforce. Reset clears the counters, the snapshot
// queue and the result valid flag and sets beta to 2.
// ----------------------------------------------------------------------------
module binary_mask_quality_metrics_core
   import bmqm_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  req_type           req_data,
   input  logic              pop,
   output logic              empty,
   output rsp_type           rsp_data,
   input  logic              valid,
   output logic              ready,
   input  logic [BETA_W-1:0] csr_beta
);

   logic              accept;
   logic              snap_push, snap_pop, snap_empty;
   snap_type          snap_wr, snap_rd;
   logic [BETA_W-1:0] beta_ff;

   assign ready  = 1'b1;
   assign accept = push & ~full;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= BETA_RESET;
      end else if (valid) begin
         beta_ff <= csr_beta;
      end
   end

   bmqm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pix       (req_data),
      .snap_push (snap_push),
      .snap      (snap_wr)
   );

   bmqm_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .W     ($bits(snap_type))
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (snap_push),
      .wr_data (snap_wr),
      .pop     (snap_pop),
      .rd_data (snap_rd),
      .full    (full),
      .empty   (snap_empty)
   );

   bmqm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .snap_empty (snap_empty),
      .snap       (snap_rd),
      .snap_pop   (snap_pop),
      .beta       (beta_ff),
      .pop        (pop),
      .empty      (empty),
      .rsp_data   (rsp_data)
   );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// frame-level check of binary_mask_quality_metrics_core: pixel beats with
// random gaps, result beats under random pop stalls, and beta rewritten
// between idle phases; every result is compared against predicted counts and
// fractions.
// ----------------------------------------------------------------------------
module testbench;
   import bmqm_pkg::*;

   class mask_metrics_tracker;
      bit [CNT_W-1:0]  tp_n, fn_n, fp_n, tn_n;
      bit              sat_seen;
      bit [BETA_W-1:0] weight;
      rsp_type         pending_metrics[$];
      int              errors;

      function new();
         tp_n = '0;
         fn_n = '0;
         fp_n = '0;
         tn_n = '0;
         sat_seen = 1'b0;
         weight = BETA_RESET;
         errors = 0;
      endfunction

      function void set_beta(bit [BETA_W-1:0] b);
         weight = b;
      endfunction

      function int pending();
         return pending_metrics.size();
      endfunction

      function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] c);
         if (&c) begin
            sat_seen = 1'b1;
            return c;
         end
         return c + 1'b1;
      endfunction

      function bit [63:0] q_ratio(bit [63:0] num, bit [63:0] den);
         if (den == 0) return 0;
         if (num >= den) return 64'd1 << FRAC_W;
         return (num << FRAC_W) / den;
      endfunction

      function void note_pixel(req_type px);
         bit        t, p;
         bit [63:0] tp, fn, fp, tn, b2, prec, rec, spec, f1, fb;
         rsp_type   want;
         t = |px.truth_pixel;
         p = |px.pred_pixel;
         if (t && p) tp_n = bump(tp_n);
         else if (t) fn_n = bump(fn_n);
         else if (p) fp_n = bump(fp_n);
         else tn_n = bump(tn_n);
         if (!px.frame_end) return;
         tp = tp_n;
         fn = fn_n;
         fp = fp_n;
         tn = tn_n;
         b2 = weight * weight;
         if (tp == 0) begin
            prec = 0;
            rec = 0;
            f1 = 0;
            fb = 0;
         end else begin
            prec = q_ratio(tp, tp + fp);
            rec = q_ratio(tp, tp + fn);
            f1 = q_ratio(2 * tp, 2 * tp + fp + fn);
            fb = q_ratio((1 + b2) * tp, (1 + b2) * tp + b2 * fn + fp);
         end
         spec = (tn == 0) ? 64'd0 : q_ratio(tn, tn + fp);
         want.true_pos = tp_n;
         want.false_neg = fn_n;
         want.false_pos = fp_n;
         want.true_neg = tn_n;
         want.precision_q = prec[Q_W-1:0];
         want.recall_q = rec[Q_W-1:0];
         want.specificity_q = spec[Q_W-1:0];
         want.f_one_q = f1[Q_W-1:0];
         want.f_beta_q = fb[Q_W-1:0];
         want.count_overflow = sat_seen;
         pending_metrics = {pending_metrics, want};
         tp_n = '0;
         fn_n = '0;
         fp_n = '0;
         tn_n = '0;
         sat_seen = 1'b0;
      endfunction

      function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_metrics.size() == 0) begin
            $error("result beat with no frame waiting");
            errors++;
            return;
         end
         want = pending_metrics.pop_front();
         cmp_field("true_pos", want.true_pos, got.true_pos);
         cmp_field("false_neg", want.false_neg, got.false_neg);
         cmp_field("false_pos", want.false_pos, got.false_pos);
         cmp_field("true_neg", want.true_neg, got.true_neg);
         cmp_field("precision_q", want.precision_q, got.precision_q);
         cmp_field("recall_q", want.recall_q, got.recall_q);
         cmp_field("specificity_q", want.specificity_q, got.specificity_q);
         cmp_field("f_one_q", want.f_one_q, got.f_one_q);
         cmp_field("f_beta_q", want.f_beta_q, got.f_beta_q);
         cmp_field("count_overflow", want.count_overflow, got.count_overflow);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   req_type           req_data = '0;
   logic              pop = 1'b0;
   logic              empty;
   rsp_type           rsp_data;
   logic              valid = 1'b0;
   logic              ready;
   logic [BETA_W-1:0] csr_beta = '0;

   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;

   mask_metrics_tracker tracker = new();

   binary_mask_quality_metrics_core uut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data),
      .valid    (valid),
      .ready    (ready),
      .csr_beta (csr_beta)
   );

   always #10 clock = ~clock;

   function automatic req_type make_pixel(logic [PIX_W-1:0] t, logic [PIX_W-1:0] p, logic e);
      req_type px;
      px.truth_pixel = t;
      px.pred_pixel = p;
      px.frame_end = e;
      return px;
   endfunction

   task automatic send_pixel(input req_type px);
      int gap;
      if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      push <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (full !== 1'b0);
      tracker.note_pixel(px);
   endtask

   task automatic send_frame(input int len, input int truth_pct, input int match_pct);
      bit               t, p;
      logic [PIX_W-1:0] tv, pv;
      for (int i = 0; i < len; i++) begin
         t = $urandom_range(0, 99) < truth_pct;
         p = ($urandom_range(0, 99) < match_pct) ? t : !t;
         tv = t ? PIX_W'($urandom_range(1, 255)) : '0;
         pv = p ? PIX_W'($urandom_range(1, 255)) : '0;
         send_pixel(make_pixel(tv, pv, i == len - 1));
      end
   endtask

   task automatic run_random(input int items);
      int sent, len;
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 30);
         send_frame(len, $urandom_range(0, 100), $urandom_range(0, 100));
         sent += len;
      end
   endtask

   // hold the input until every frame has come back, then let the back end drain
   task automatic settle_idle();
      @(negedge clock);
      push <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_beta(input logic [BETA_W-1:0] b);
      @(negedge clock);
      valid <= 1'b1;
      csr_beta <= b;
      do @(posedge clock); while (ready !== 1'b1);
      tracker.set_beta(b);
      @(negedge clock);
      valid <= 1'b0;
   endtask

   task automatic run_directed();
      // single-pixel frames: all hit, all background, false alarm only, miss only
      send_pixel(make_pixel(8'hFF, 8'hFF, 1'b1));
      send_pixel(make_pixel(8'h00, 8'h00, 1'b1));
      send_pixel(make_pixel(8'h00, 8'h01, 1'b1));
      send_pixel(make_pixel(8'h01, 8'h00, 1'b1));
      // mixed frame
      send_pixel(make_pixel(8'h80, 8'h80, 1'b0));
      send_pixel(make_pixel(8'hFF, 8'h00, 1'b0));
      send_pixel(make_pixel(8'h00, 8'hFF, 1'b0));
      send_pixel(make_pixel(8'h00, 8'h00, 1'b0));
      send_pixel(make_pixel(8'h01, 8'h01, 1'b0));
      send_pixel(make_pixel(8'h00, 8'h00, 1'b1));
      // alternating bit patterns
      send_pixel(make_pixel(8'hAA, 8'h55, 1'b0));
      send_pixel(make_pixel(8'h55, 8'hAA, 1'b0));
      send_pixel(make_pixel(8'h0F, 8'h00, 1'b0));
      send_pixel(make_pixel(8'h00, 8'hF0, 1'b1));
      // frame with no hits: two background pixels and one miss
      send_pixel(make_pixel(8'h00, 8'h00, 1'b0));
      send_pixel(make_pixel(8'h00, 8'h00, 1'b0));
      send_pixel(make_pixel(8'hFF, 8'h00, 1'b1));
   endtask

   initial begin : result_sink
      int stall;
      rsp_type got;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
         stall = rx_calm ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            @(negedge clock);
            pop <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         pop <= 1'b1;
         do @(posedge clock); while (empty !== 1'b0);
         got = rsp_data;
         tracker.check_result(got);
      end
   end

   initial begin : stimulus
      logic [BETA_W-1:0] b;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      settle_idle();
      for (int k = 0; k < 6; k++) begin
         case (k)
            0: b = 4'd1;
            1: b = 4'd15;
            2: b = 4'd0;
            5: b = BETA_RESET;
            default: b = BETA_W'($urandom_range(3, 14));
         endcase
         write_beta(b);
         run_random(300);
         settle_idle();
      end
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin : watchdog
      #25000000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
